// ===== rtl/core/alkd_pkg.sv =====
// shared types, codes and constants of the adc ladder key decoder
package alkd_pkg;

  localparam int MvW        = 16;
  localparam int CodeW      = 8;
  localparam int EventW     = 3;
  localparam int KeyCountW  = 3;
  localparam int WindowsW   = 16;
  localparam int NumKeys    = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 40;
  localparam int ModeW      = 2;
  localparam int StatusW    = 2;

  localparam int WindowSamplesDef = 4;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_PRESS    = 3'd1,
    EV_LONG     = 3'd2,
    EV_LONGLONG = 3'd3,
    EV_RELEASE  = 3'd4
  } alkd_event_e;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_DETECT = 2'd1,
    MODE_START  = 2'd2,
    MODE_UNUSED = 2'd3
  } alkd_mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_GOOD   = 2'd0,
    STATUS_BAD    = 2'd1,
    STATUS_BLANK  = 2'd2,
    STATUS_UNUSED = 2'd3
  } alkd_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_COUNT  = 3'd0,
    REG_KEY_ENTRY0 = 3'd1,
    REG_KEY_ENTRY1 = 3'd2,
    REG_KEY_ENTRY2 = 3'd3,
    REG_KEY_ENTRY3 = 3'd4,
    REG_KEY_ENTRY4 = 3'd5,
    REG_LONG       = 3'd6,
    REG_LONGLONG   = 3'd7
  } alkd_reg_e;

  localparam logic [KeyCountW-1:0] KeyCountRst   = 3'd5;
  localparam logic [CfgDataW-1:0]  KeyEntry0Rst  = 40'd4298244096;
  localparam logic [CfgDataW-1:0]  KeyEntry1Rst  = 40'd8615493922;
  localparam logic [CfgDataW-1:0]  KeyEntry2Rst  = 40'd12932743798;
  localparam logic [CfgDataW-1:0]  KeyEntry3Rst  = 40'd17245406084;
  localparam logic [CfgDataW-1:0]  KeyEntry4Rst  = 40'd21560689850;
  localparam logic [WindowsW-1:0]  LongRst       = 16'd10;
  localparam logic [WindowsW-1:0]  LongLongRst   = 16'd30;

  // controller to datapath
  typedef struct packed {
    logic sample_take;
    logic div_load;
    logic div_step;
    logic match_load;
    logic result_load;
  } alkd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic window_done;
    logic div_last;
  } alkd_sts_t;

endpackage

// ===== rtl/core/alkd_if.sv =====
// channel interfaces: sample input, result output and register write port
interface alkd_in_if;
  import alkd_pkg::*;
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [MvW-1:0]      sample_mv;
  logic [StatusW-1:0]  sample_status;
  modport source (output valid, mode, sample_mv, sample_status, input ready);
  modport sink   (input valid, mode, sample_mv, sample_status, output ready);
endinterface

interface alkd_out_if;
  import alkd_pkg::*;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] key_event;
  logic [CodeW-1:0]  key_code;
  logic [MvW-1:0]    mean_mv;
  logic              rearm;
  modport source (output valid, key_event, key_code, mean_mv, rearm, input ready);
  modport sink   (input valid, key_event, key_code, mean_mv, rearm, output ready);
endinterface

interface alkd_cfg_if;
  import alkd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/alkd_ctrl.sv =====
// sequencing controller: accept, divide, match, hand over result
module alkd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output alkd_pkg::alkd_cmd_t cmd_o,
  input  alkd_pkg::alkd_sts_t sts_i
);
  import alkd_pkg::*;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_DIV,
    CTL_MATCH,
    CTL_FINISH
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o             = '0;
    state_d           = state_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    in_ready_o        = (state_q == CTL_IDLE);
    case (state_q)
      CTL_IDLE: begin
        if (in_valid_i) begin
          cmd_o.sample_take = 1'b1;
          if (sts_i.window_done) begin
            cmd_o.div_load = 1'b1;
            state_d        = CTL_DIV;
          end
        end
      end
      CTL_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = CTL_MATCH;
      end
      CTL_MATCH: begin
        cmd_o.match_load = 1'b1;
        state_d          = CTL_FINISH;
      end
      CTL_FINISH: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/alkd_dp.sv =====
// datapath: window accumulator, restoring divider, key matcher, press tracking
module alkd_dp #(
  parameter int WINDOW_SAMPLES = alkd_pkg::WindowSamplesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  alkd_pkg::alkd_cmd_t             cmd_i,
  output alkd_pkg::alkd_sts_t             sts_o,
  input  logic [alkd_pkg::ModeW-1:0]      mode_i,
  input  logic [alkd_pkg::MvW-1:0]        sample_mv_i,
  input  logic [alkd_pkg::StatusW-1:0]    sample_status_i,
  input  logic                            cfg_we_i,
  input  logic [alkd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [alkd_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [alkd_pkg::EventW-1:0]     key_event_o,
  output logic [alkd_pkg::CodeW-1:0]      key_code_o,
  output logic [alkd_pkg::MvW-1:0]        mean_mv_o,
  output logic                            rearm_o
);
  import alkd_pkg::*;

  localparam int CntW  = $clog2(WINDOW_SAMPLES + 1);
  localparam int SumW  = MvW + CntW;
  localparam int StepW = $clog2(SumW);

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_PRESS,
    PR_LONG,
    PR_LONGLONG
  } press_e;

  // configuration
  logic [KeyCountW-1:0] key_count_q;
  logic [CfgDataW-1:0]  key_entry_q [NumKeys];
  logic [WindowsW-1:0]  long_q, longlong_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q    <= KeyCountRst;
      key_entry_q[0] <= KeyEntry0Rst;
      key_entry_q[1] <= KeyEntry1Rst;
      key_entry_q[2] <= KeyEntry2Rst;
      key_entry_q[3] <= KeyEntry3Rst;
      key_entry_q[4] <= KeyEntry4Rst;
      long_q         <= LongRst;
      longlong_q     <= LongLongRst;
    end else if (cfg_we_i) begin
      case (alkd_reg_e'(cfg_index_i))
        REG_KEY_COUNT:  key_count_q    <= cfg_data_i[KeyCountW-1:0];
        REG_KEY_ENTRY0: key_entry_q[0] <= cfg_data_i;
        REG_KEY_ENTRY1: key_entry_q[1] <= cfg_data_i;
        REG_KEY_ENTRY2: key_entry_q[2] <= cfg_data_i;
        REG_KEY_ENTRY3: key_entry_q[3] <= cfg_data_i;
        REG_KEY_ENTRY4: key_entry_q[4] <= cfg_data_i;
        REG_LONG:       long_q         <= cfg_data_i[WindowsW-1:0];
        REG_LONGLONG:   longlong_q     <= cfg_data_i[WindowsW-1:0];
        default: ;
      endcase
    end
  end

  // sample window
  logic            enabled_q;
  logic [CntW-1:0] slot_q, valid_q;
  logic [SumW-1:0] sum_q;
  logic            take, good, window_end;
  logic [CntW-1:0] slot_inc, cnt_next;
  logic [SumW-1:0] sum_next;

  always_comb begin
    good       = (alkd_status_e'(sample_status_i) == STATUS_GOOD);
    take       = (alkd_mode_e'(mode_i) == MODE_SAMPLE) && enabled_q &&
                 (good || alkd_status_e'(sample_status_i) == STATUS_BLANK);
    slot_inc   = slot_q + CntW'(1);
    window_end = take && (slot_inc == CntW'(WINDOW_SAMPLES));
    sum_next   = good ? (sum_q + SumW'(sample_mv_i)) : sum_q;
    cnt_next   = good ? (valid_q + CntW'(1)) : valid_q;
  end

  assign sts_o.window_done = window_end;

  // divider
  logic [CntW-1:0]  rem_q, dvsr_q;
  logic [SumW-1:0]  quo_q;
  logic [StepW-1:0] step_q;
  logic             zero_q;
  logic [CntW:0]    rem_shift, rem_diff;
  logic             q_bit;

  always_comb begin
    rem_shift = {rem_q, quo_q[SumW-1]};
    rem_diff  = rem_shift - {1'b0, dvsr_q};
    q_bit     = (rem_shift >= {1'b0, dvsr_q});
  end

  assign sts_o.div_last = (step_q == StepW'(SumW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q  <= sum_next;
      rem_q  <= '0;
      dvsr_q <= cnt_next;
      zero_q <= (cnt_next == '0);
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SumW-2:0], q_bit};
      rem_q  <= q_bit ? rem_diff[CntW-1:0] : rem_shift[CntW-1:0];
      step_q <= step_q + StepW'(1);
    end
  end

  // key matcher, first entry in use that holds the mean wins
  logic [MvW-1:0]       mean;
  logic [KeyCountW-1:0] n_keys;
  logic [MvW-1:0]       upper_last;
  logic [CodeW-1:0]     hit_code, match_q;

  always_comb begin
    mean     = quo_q[MvW-1:0];
    n_keys   = (key_count_q > KeyCountW'(NumKeys)) ? KeyCountW'(NumKeys) : key_count_q;
    case (n_keys)
      3'd1:    upper_last = key_entry_q[0][31:16];
      3'd2:    upper_last = key_entry_q[1][31:16];
      3'd3:    upper_last = key_entry_q[2][31:16];
      3'd4:    upper_last = key_entry_q[3][31:16];
      default: upper_last = key_entry_q[4][31:16];
    endcase
    hit_code = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (KeyCountW'(i) < n_keys && mean >= key_entry_q[i][15:0] &&
          mean < key_entry_q[i][31:16]) begin
        hit_code = key_entry_q[i][39:32];
      end
    end
    if (n_keys == '0 || mean < key_entry_q[0][15:0] || mean > upper_last) begin
      hit_code = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match_load) match_q <= hit_code;
  end

  // press tracking
  press_e              press_q, press_d;
  logic [CodeW-1:0]    held_code_q, held_code_d;
  logic [WindowsW-1:0] held_win_q, held_win_d, held_inc;
  logic [EventW-1:0]   ev_d;
  logic [CodeW-1:0]    code_d;
  logic                rearm_d;

  always_comb begin
    held_inc    = (held_win_q == '1) ? held_win_q : held_win_q + WindowsW'(1);
    press_d     = press_q;
    held_code_d = held_code_q;
    held_win_d  = held_win_q;
    ev_d        = EV_NONE;
    code_d      = '0;
    rearm_d     = 1'b0;
    if (zero_q) begin
      code_d  = held_code_q;
      rearm_d = 1'b1;
    end else if (match_q != '0) begin
      rearm_d = 1'b1;
      case (press_q)
        PR_IDLE: begin
          press_d     = PR_PRESS;
          held_code_d = match_q;
          held_win_d  = '0;
          ev_d        = EV_PRESS;
        end
        PR_PRESS: begin
          held_win_d = held_inc;
          if (held_inc >= long_q) begin
            press_d = PR_LONG;
            ev_d    = EV_LONG;
          end
        end
        PR_LONG: begin
          held_win_d = held_inc;
          if (held_inc >= longlong_q) begin
            press_d = PR_LONGLONG;
            ev_d    = EV_LONGLONG;
          end
        end
        default: held_win_d = held_inc;
      endcase
      code_d = held_code_d;
    end else if (press_q != PR_IDLE) begin
      press_d     = PR_IDLE;
      ev_d        = EV_RELEASE;
      code_d      = held_code_q;
      held_code_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      slot_q      <= '0;
      valid_q     <= '0;
      sum_q       <= '0;
      press_q     <= PR_IDLE;
      held_code_q <= '0;
      held_win_q  <= '0;
    end else begin
      if (cmd_i.sample_take) begin
        case (alkd_mode_e'(mode_i))
          MODE_DETECT: begin
            slot_q      <= '0;
            valid_q     <= '0;
            sum_q       <= '0;
            press_q     <= PR_IDLE;
            held_code_q <= '0;
            held_win_q  <= '0;
          end
          MODE_START: begin
            slot_q    <= '0;
            valid_q   <= '0;
            sum_q     <= '0;
            enabled_q <= 1'b1;
          end
          MODE_SAMPLE: begin
            if (window_end) begin
              slot_q    <= '0;
              valid_q   <= '0;
              sum_q     <= '0;
              enabled_q <= 1'b0;
            end else if (take) begin
              slot_q  <= slot_inc;
              valid_q <= cnt_next;
              sum_q   <= sum_next;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.result_load) begin
        press_q     <= press_d;
        held_code_q <= held_code_d;
        held_win_q  <= held_win_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      key_event_o <= ev_d;
      key_code_o  <= code_d;
      mean_mv_o   <= zero_q ? '0 : mean;
      rearm_o     <= rearm_d;
    end
  end

endmodule

// ===== rtl/core/adc_ladder_key_decoder.sv =====
// top level of the adc ladder key decoder
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+--------------------------------------
//  in_chan_i  | in  | valid / ready      | mode, sample_mv, sample_status
//  res_chan_o | out | valid / ready      | key_event, key_code, mean_mv, rearm
//  cfg_chan_i | in  | valid / ready (=1) | index, data
//
// a transaction that does not end a window is taken as soon as the block is idle
// a window-ending sample starts the restoring divider, one quotient bit a cycle,
// then the match step and the hand-over; no input is taken until the result is loaded
// the result sits in an output register, so the next transaction is taken
// while it waits; a new result waits only if the old one is still not taken
// reset is asynchronous, active low, and needs no clearing pass
module adc_ladder_key_decoder #(
  parameter int WINDOW_SAMPLES = alkd_pkg::WindowSamplesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alkd_in_if.sink    in_chan_i,
  alkd_out_if.source res_chan_o,
  alkd_cfg_if.sink   cfg_chan_i
);
  import alkd_pkg::*;

  alkd_cmd_t cmd;
  alkd_sts_t sts;

  // register writes always taken; user, not block, keeps them to quiet times
  assign cfg_chan_i.ready = 1'b1;

  alkd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (res_chan_o.valid),
    .out_ready_i (res_chan_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  alkd_dp #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_chan_i.mode),
    .sample_mv_i     (in_chan_i.sample_mv),
    .sample_status_i (in_chan_i.sample_status),
    .cfg_we_i        (cfg_chan_i.valid),
    .cfg_index_i     (cfg_chan_i.index),
    .cfg_data_i      (cfg_chan_i.data),
    .key_event_o     (res_chan_o.key_event),
    .key_code_o      (res_chan_o.key_code),
    .mean_mv_o       (res_chan_o.mean_mv),
    .rearm_o         (res_chan_o.rearm)
  );

  // a finished window blocks new samples until its result is built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_load |=> !in_chan_i.ready)
    else $error("input taken right after a window ended");

  // no sample is taken while the divider is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !in_chan_i.ready)
    else $error("input ready during division");

  // a loaded result is always offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |=> res_chan_o.valid)
    else $error("result loaded but not offered");

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |-> (!res_chan_o.valid || res_chan_o.ready))
    else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the adc ladder key decoder: random windows, key presses and registers
module tb_top;
  import alkd_pkg::*;

  // window length the block is built with, kept in step with the instance below
  localparam int Slots = WindowSamplesDef;
  localparam int CycleLimit = 1_000_000;
  // settle time after the drain, long enough for a window-ending sample to finish
  localparam int SettleCycles = 40;
  localparam int DrainCap = 20_000;
  // long receiver hold-off, long enough to back the input up
  localparam int LongHold = 600;

  // press tracking of the predictor
  typedef enum logic [1:0] {
    HOLD_IDLE     = 2'd0,
    HOLD_PRESS    = 2'd1,
    HOLD_LONG     = 2'd2,
    HOLD_LONGLONG = 2'd3
  } hold_state_e;

  typedef struct packed {
    alkd_event_e        key_event;
    logic [CodeW-1:0]   key_code;
    logic [MvW-1:0]     mean_mv;
    logic               rearm;
  } key_result_t;

  // predictor and store of expected key results
  class key_decoder_sb;
    logic [KeyCountW-1:0] key_count;
    logic [CfgDataW-1:0]  key_entry [NumKeys];
    logic [WindowsW-1:0]  long_win;
    logic [WindowsW-1:0]  longlong_win;

    bit                   reading_en;
    logic [6:0]           slot_cnt;
    logic [21:0]          mv_sum;
    logic [6:0]           good_cnt;
    hold_state_e          hold;
    logic [CodeW-1:0]     held_code;
    logic [WindowsW-1:0]  held_win;

    key_result_t          expected_q [$];
    int unsigned          errors;

    function new();
      key_count    = KeyCountRst;
      key_entry[0] = KeyEntry0Rst;
      key_entry[1] = KeyEntry1Rst;
      key_entry[2] = KeyEntry2Rst;
      key_entry[3] = KeyEntry3Rst;
      key_entry[4] = KeyEntry4Rst;
      long_win     = LongRst;
      longlong_win = LongLongRst;
      reading_en   = 1'b0;
      clear_window();
      hold         = HOLD_IDLE;
      held_code    = '0;
      held_win     = '0;
      errors       = 0;
    endfunction

    function void clear_window();
      slot_cnt = '0;
      mv_sum   = '0;
      good_cnt = '0;
    endfunction

    function void set_reg(alkd_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_KEY_COUNT: key_count = data[KeyCountW-1:0];
        REG_KEY_ENTRY0, REG_KEY_ENTRY1, REG_KEY_ENTRY2, REG_KEY_ENTRY3,
        REG_KEY_ENTRY4: key_entry[int'(idx) - int'(REG_KEY_ENTRY0)] = data;
        REG_LONG:      long_win = data[WindowsW-1:0];
        REG_LONGLONG:  longlong_win = data[WindowsW-1:0];
        default: ;
      endcase
    endfunction

    // first window that holds the mean, after the overall range check
    function logic [CodeW-1:0] match_key(logic [MvW-1:0] mean);
      int n;
      n = (key_count > 3'd5) ? NumKeys : int'(key_count);
      if (n == 0) return '0;
      if (mean < key_entry[0][15:0] || mean > key_entry[n-1][31:16]) return '0;
      for (int i = 0; i < n; i++) begin
        if (mean >= key_entry[i][15:0] && mean < key_entry[i][31:16])
          return key_entry[i][39:32];
      end
      return '0;
    endfunction

    function void bump_held();
      if (held_win != 16'hFFFF) held_win = held_win + 16'd1;
    endfunction

    function void note_input(alkd_mode_e mode, logic [MvW-1:0] mv, alkd_status_e status);
      key_result_t      res;
      logic [MvW-1:0]   mean;
      logic [CodeW-1:0] code;
      res = '{key_event: EV_NONE, key_code: '0, mean_mv: '0, rearm: 1'b0};
      case (mode)
        MODE_DETECT: begin
          clear_window();
          hold      = HOLD_IDLE;
          held_code = '0;
          held_win  = '0;
          return;
        end
        MODE_START: begin
          clear_window();
          reading_en = 1'b1;
          return;
        end
        MODE_SAMPLE: ;
        default: return;
      endcase
      if (status == STATUS_BAD || status == STATUS_UNUSED || !reading_en) return;
      slot_cnt = slot_cnt + 7'd1;
      if (status == STATUS_GOOD) begin
        mv_sum   = mv_sum + 22'(mv);
        good_cnt = good_cnt + 7'd1;
      end
      if (slot_cnt < 7'(Slots)) return;
      reading_en = 1'b0;
      if (good_cnt == 0) begin
        clear_window();
        res.key_code = held_code;
        res.rearm    = 1'b1;
        expected_q.push_back(res);
        return;
      end
      mean = 16'(mv_sum / 22'(good_cnt));
      clear_window();
      res.mean_mv = mean;
      code = match_key(mean);
      if (code != 0) begin
        case (hold)
          HOLD_IDLE: begin
            held_code     = code;
            hold          = HOLD_PRESS;
            held_win      = '0;
            res.key_event = EV_PRESS;
          end
          HOLD_PRESS: begin
            bump_held();
            if (held_win >= long_win) begin
              hold          = HOLD_LONG;
              res.key_event = EV_LONG;
            end
          end
          HOLD_LONG: begin
            bump_held();
            if (held_win >= longlong_win) begin
              hold          = HOLD_LONGLONG;
              res.key_event = EV_LONGLONG;
            end
          end
          default: bump_held();
        endcase
        // a different key while one is held keeps the held code
        res.key_code = held_code;
        res.rearm    = 1'b1;
      end else if (hold != HOLD_IDLE) begin
        hold          = HOLD_IDLE;
        res.key_event = EV_RELEASE;
        res.key_code  = held_code;
        held_code     = '0;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(key_result_t got);
      key_result_t want;
      if (expected_q.size() == 0) begin
        $error("key result with nothing expected: event %0d code %0d mean %0d rearm %0d",
               got.key_event, got.key_code, got.mean_mv, got.rearm);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.key_event !== want.key_event) begin
        $error("key_event expected %0d actual %0d", want.key_event, got.key_event);
        errors++;
      end
      if (got.key_code !== want.key_code) begin
        $error("key_code expected %0d actual %0d", want.key_code, got.key_code);
        errors++;
      end
      if (got.mean_mv !== want.mean_mv) begin
        $error("mean_mv expected %0d actual %0d", want.mean_mv, got.mean_mv);
        errors++;
      end
      if (got.rearm !== want.rearm) begin
        $error("rearm expected %0d actual %0d", want.rearm, got.rearm);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  alkd_in_if  in_if ();
  alkd_out_if res_if ();
  alkd_cfg_if cfg_if ();

  adc_ladder_key_decoder #(
    .WINDOW_SAMPLES (Slots)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .res_chan_o (res_if),
    .cfg_chan_i (cfg_if)
  );

  key_decoder_sb sb;
  key_result_t   seen_result;
  int unsigned   cycles;
  int            fed_items;
  bit            long_hold_req;

  // idle streaks of the two sides: a run of items either with random gaps or with none
  int tx_run, rx_run;
  bit tx_calm, rx_calm;

  // clock and the one reset at the start
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always #4 clk_i = ~clk_i;

  function automatic int pause_len(inout int run_left, inout bit calm);
    if (run_left <= 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // monitor: everything sampled at the rising edge, results checked before the
  // input transaction of the same edge is noted, since a result is never caused
  // by the transaction taken at the same edge
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("adc_ladder_key_decoder: mismatch");
      $finish;
    end
    if (rst_ni && sb != null) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.set_reg(alkd_reg_e'(cfg_if.index), cfg_if.data);
      if (res_if.valid && res_if.ready) begin
        seen_result.key_event = alkd_event_e'(res_if.key_event);
        seen_result.key_code  = res_if.key_code;
        seen_result.mean_mv   = res_if.mean_mv;
        seen_result.rearm     = res_if.rearm;
        sb.check_result(seen_result);
      end
      if (in_if.valid && in_if.ready)
        sb.note_input(alkd_mode_e'(in_if.mode), in_if.sample_mv,
                      alkd_status_e'(in_if.sample_status));
    end
  end

  // result receiver: random stall before each transaction, plus one long hold-off
  // on request so that the output register fills and the input backs up
  initial begin
    int stall;
    res_if.ready = 1'b0;
    rx_run = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        res_if.ready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        stall = pause_len(rx_run, rx_calm);
        if (stall > 0) begin
          res_if.ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // one input transaction, driven at the falling edge after a random gap
  task automatic send_item(alkd_mode_e mode, logic [MvW-1:0] mv, alkd_status_e status);
    int gap;
    gap = long_hold_req ? 0 : pause_len(tx_run, tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.mode          = mode;
    in_if.sample_mv     = mv;
    in_if.sample_status = status;
    do @(posedge clk_i); while (!in_if.ready);
    // ignored items do not count toward the stimulus length
    if (mode != MODE_UNUSED &&
        !(mode == MODE_SAMPLE && (status == STATUS_BAD || status == STATUS_UNUSED)))
      fed_items++;
  endtask

  task automatic write_reg(alkd_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // let every expected result come out, then allow the divider time to finish
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0 && guard < DrainCap) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // start command followed by one full window; good samples drawn from [lo, hi]
  task automatic play_window(logic [MvW-1:0] lo, logic [MvW-1:0] hi, bit noisy);
    int taken;
    int pick;
    send_item(MODE_START, 16'($urandom), alkd_status_e'($urandom_range(0, 3)));
    taken = 0;
    while (taken < Slots) begin
      pick = noisy ? $urandom_range(0, 99) : 99;
      if (pick < 6) begin
        send_item(MODE_SAMPLE, 16'($urandom), (pick < 3) ? STATUS_BAD : STATUS_UNUSED);
      end else begin
        if (pick < 18) send_item(MODE_SAMPLE, 16'($urandom), STATUS_BLANK);
        else send_item(MODE_SAMPLE, 16'($urandom_range(lo, hi)), STATUS_GOOD);
        taken++;
      end
    end
  endtask

  // key held for a number of windows, then let go
  task automatic press_episode();
    int n, k, lim, hold_len, shape;
    logic [CfgDataW-1:0] e;
    logic [MvW-1:0] lo, hi;
    n = (sb.key_count > 3'd5) ? NumKeys : int'(sb.key_count);
    k = (n == 0) ? 0 : $urandom_range(0, n - 1);
    e = sb.key_entry[k];
    lo = e[15:0];
    hi = e[31:16] - 16'd1;
    if (e[31:16] <= e[15:0]) begin
      lo = '0;
      hi = '1;
    end
    lim = int'(sb.longlong_win) + 3;
    if (lim > 40) lim = 40;
    hold_len = $urandom_range(1, lim);
    repeat (hold_len) begin
      shape = $urandom_range(0, 9);
      case (shape)
        0: play_window(lo, lo, 1'b1);
        1: play_window(hi, hi, 1'b1);
        // exclusive upper bound of the window
        2: play_window(e[31:16], e[31:16], 1'b1);
        default: play_window(lo, hi, 1'b1);
      endcase
    end
    play_window('0, '1, 1'b1);
  endtask

  task automatic run_phase(int quota);
    int pick;
    fed_items = 0;
    while (fed_items < quota) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        press_episode();
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6))
          send_item(alkd_mode_e'($urandom_range(0, 3)), 16'($urandom),
                    alkd_status_e'($urandom_range(0, 3)));
      end else if (pick < 18) begin
        // window cut short by a detect edge or a fresh start
        send_item(MODE_START, 16'($urandom), STATUS_GOOD);
        repeat ($urandom_range(0, Slots - 1))
          send_item(MODE_SAMPLE, 16'($urandom), STATUS_GOOD);
        send_item($urandom_range(0, 1) ? MODE_DETECT : MODE_START, 16'($urandom),
                  STATUS_GOOD);
      end else begin
        play_window('0, '1, 1'b1);
      end
    end
    wait_idle();
  endtask

  // contiguous key table; zero_codes puts code 0 on every second key
  task automatic write_table(bit zero_codes);
    int lo_b, up_b;
    logic [CodeW-1:0] code;
    lo_b = $urandom_range(0, 3000);
    for (int i = 0; i < NumKeys; i++) begin
      up_b = lo_b + $urandom_range(40, 12000);
      if (up_b > 65535) up_b = 65535;
      code = (zero_codes && (i % 2 == 1)) ? 8'd0 : 8'($urandom_range(1, 255));
      write_reg(alkd_reg_e'(int'(REG_KEY_ENTRY0) + i), {code, 16'(up_b), 16'(lo_b)});
      lo_b = up_b;
    end
  endtask

  task automatic write_timing(logic [WindowsW-1:0] lw, logic [WindowsW-1:0] llw);
    write_reg(REG_LONG, {24'd0, lw});
    write_reg(REG_LONGLONG, {24'd0, llw});
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.mode          = MODE_SAMPLE;
    in_if.sample_mv     = '0;
    in_if.sample_status = STATUS_GOOD;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_KEY_COUNT;
    cfg_if.data         = '0;
    long_hold_req       = 1'b0;
    tx_run              = 0;
    cycles              = 0;
    sb = new();
    wait (rst_ni);

    // directed part on the reset table
    // sample before any start and an unused mode: both dropped
    send_item(MODE_SAMPLE, 16'hFFFF, STATUS_GOOD);
    send_item(MODE_UNUSED, 16'hAAAA, STATUS_UNUSED);
    // window of blank slots only
    send_item(MODE_START, 16'h0000, STATUS_GOOD);
    repeat (Slots) send_item(MODE_SAMPLE, 16'h5555, STATUS_BLANK);
    // bad and unused status skipped, a blank slot, full-scale and zero readings
    send_item(MODE_START, 16'h0000, STATUS_GOOD);
    send_item(MODE_SAMPLE, 16'd1234, STATUS_BAD);
    send_item(MODE_SAMPLE, 16'd4321, STATUS_UNUSED);
    send_item(MODE_SAMPLE, 16'hFFFF, STATUS_GOOD);
    send_item(MODE_SAMPLE, 16'hFFFF, STATUS_GOOD);
    send_item(MODE_SAMPLE, 16'h0000, STATUS_BLANK);
    send_item(MODE_SAMPLE, 16'h0000, STATUS_GOOD);
    // press on the first key, a different key while held, then a detect edge
    play_window(sb.key_entry[0][15:0], sb.key_entry[0][15:0], 1'b0);
    play_window(sb.key_entry[1][15:0], sb.key_entry[1][15:0], 1'b0);
    send_item(MODE_DETECT, 16'h0000, STATUS_GOOD);
    // off-key window at full scale after the detect edge: no release
    play_window(16'hFFFF, 16'hFFFF, 1'b0);
    wait_idle();

    // random part, one register setting per phase
    run_phase(280);

    // full table, very short long / long-long counts, with the long hold-off
    write_reg(REG_KEY_COUNT, 40'd5);
    write_table(1'b0);
    write_timing(16'd1, 16'd2);
    long_hold_req = 1'b1;
    run_phase(300);

    // no key in use
    write_reg(REG_KEY_COUNT, 40'd0);
    run_phase(250);

    // count above five, keys with code 0, equal thresholds
    write_reg(REG_KEY_COUNT, 40'd7);
    write_table(1'b1);
    write_timing(16'd3, 16'd3);
    run_phase(300);

    // single key spanning almost the whole scale, others at the extremes
    write_reg(REG_KEY_COUNT, 40'd1);
    write_reg(REG_KEY_ENTRY0, 40'hFF_FFFF_0000);
    write_reg(REG_KEY_ENTRY1, '0);
    write_reg(REG_KEY_ENTRY2, '1);
    write_reg(REG_KEY_ENTRY3, '0);
    write_reg(REG_KEY_ENTRY4, '1);
    write_timing(16'hFFFF, 16'hFFFF);
    run_phase(250);

    // fully random keys, overlapping or empty windows allowed
    write_reg(REG_KEY_COUNT, 40'd6);
    for (int i = 0; i < NumKeys; i++)
      write_reg(alkd_reg_e'(int'(REG_KEY_ENTRY0) + i), 40'({$urandom, $urandom}));
    write_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)));
    run_phase(300);

    // partial table with a raised floor
    write_reg(REG_KEY_COUNT, 40'd3);
    write_table(1'b0);
    write_timing(16'd2, 16'd6);
    run_phase(300);

    if (sb.pending() != 0) begin
      $error("%0d key results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("adc_ladder_key_decoder: match");
    end else begin
      $display("adc_ladder_key_decoder: mismatch");
    end
    $finish;
  end

endmodule
